### rtl/fbt_pkg.sv
// Shared types and constants of the page framebuffer tile blitter.
`timescale 1ns / 1ps
package fbt_pkg;

   // Default panel geometry
   localparam int PAGES_DEF   = 16;
   localparam int COLUMNS_DEF = 240;

   // Width of an unclipped address product (page * columns + column)
   localparam int FULL_AW = 14;

   // Operation codes carried in the func field
   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_MERGE = 2'd1,
      FUNC_LINE  = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   // Store access kinds issued by the sequencer
   typedef enum logic [1:0] {
      SOP_NONE  = 2'd0,
      SOP_CLEAR = 2'd1,
      SOP_RMW   = 2'd2,
      SOP_READ  = 2'd3
   } store_op_type;

   typedef struct packed {
      store_op_type op;
      logic [7:0]   bits;
   } store_cmd_type;

endpackage

### rtl/fbt_ifs.sv
// Request and response channel interfaces of the page framebuffer tile blitter.
`timescale 1ns / 1ps
interface fbt_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] start_row;
   logic [7:0] start_col;
   logic [4:0] tile_page;
   logic [7:0] tile_col;
   logic [7:0] tile_byte;
   logic [7:0] line_rows;
   logic [7:0] line_cols;
   logic [3:0] read_page;
   logic [7:0] read_column;

   modport source (
      output valid, func, start_row, start_col, tile_page, tile_col, tile_byte,
             line_rows, line_cols, read_page, read_column,
      input  ready
   );
   modport sink (
      input  valid, func, start_row, start_col, tile_page, tile_col, tile_byte,
             line_rows, line_cols, read_page, read_column,
      output ready
   );
endinterface

interface fbt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;

   modport source (output valid, pixel_byte, input ready);
   modport sink (input valid, pixel_byte, output ready);
endinterface

### rtl/page_framebuffer_tile_blit_top.sv
// Top level of the page framebuffer tile blitter.
// One request at a time: a new one is accepted only after the previous response is loaded.
// Read and merge skip the store when clipped; a merge also touches the next page when unaligned.
// A clear walks every location; a line visits each page, drawing its columns, or is skipped.
// Reset runs a clearing pass over all PAGES*COLUMNS locations (3840 by default); no transfer
// is accepted until it ends.
`timescale 1ns / 1ps
module page_framebuffer_tile_blit_top import fbt_pkg::*; #(
   parameter int PAGES   = PAGES_DEF,
   parameter int COLUMNS = COLUMNS_DEF
) (
   input logic       clock,
   input logic       reset,
   fbt_req_if.sink   req_if,
   fbt_rsp_if.source rsp_if
);

   localparam int DEPTH = PAGES * COLUMNS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   store_cmd_type cmd;
   logic [AW-1:0] cmd_addr;
   logic [7:0]    rdata;

   // Sequence operations over the store
   fbt_seq #(
      .PAGES   (PAGES),
      .COLUMNS (COLUMNS),
      .DEPTH   (DEPTH),
      .AW      (AW)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .cmd      (cmd),
      .cmd_addr (cmd_addr),
      .rdata    (rdata)
   );

   // Hold the frame store
   fbt_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cmd_addr (cmd_addr),
      .rdata    (rdata)
   );

endmodule

### rtl/fbt_store.sv
// Frame store memory with a registered read and a read-modify-write stage.
`timescale 1ns / 1ps
module fbt_store import fbt_pkg::*; #(
   parameter int DEPTH = PAGES_DEF * COLUMNS_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  store_cmd_type cmd,
   input  logic [AW-1:0] cmd_addr,
   output logic [7:0]    rdata
);

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rdata_ff;
   logic          pend_ff;
   logic [AW-1:0] pend_addr_ff;
   logic [7:0]    pend_bits_ff;

   assign rdata = rdata_ff;

   // Track a pending write-back of a read-modify-write
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= (cmd.op == SOP_RMW);
      end
   end

   // Hold the address and bits of the pending write-back
   always_ff @(posedge clock) begin
      pend_addr_ff <= cmd_addr;
      pend_bits_ff <= cmd.bits;
   end

   // Read port: registered data
   always_ff @(posedge clock) begin
      if (cmd.op == SOP_RMW || cmd.op == SOP_READ) begin
         rdata_ff <= mem[cmd_addr];
      end
   end

   // Write port: merge the pending write-back, otherwise clear
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         mem[pend_addr_ff] <= rdata_ff | pend_bits_ff;
      end else if (cmd.op == SOP_CLEAR) begin
         mem[cmd_addr] <= 8'h00;
      end
   end

endmodule

### rtl/fbt_seq.sv
// Operation sequencer: walks the frame store for clear, merge, line and read.
`timescale 1ns / 1ps
module fbt_seq import fbt_pkg::*; #(
   parameter int PAGES   = PAGES_DEF,
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int DEPTH   = PAGES * COLUMNS,
   parameter int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   fbt_req_if.sink       req_if,
   fbt_rsp_if.source     rsp_if,
   output store_cmd_type cmd,
   output logic [AW-1:0] cmd_addr,
   input  logic [7:0]    rdata
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MERGE_HI,
      ST_MERGE_LO,
      ST_LINE_PAGE,
      ST_LINE_COL,
      ST_READ,
      ST_DONE
   } state_type;

   state_type     state_ff;
   logic [AW-1:0] clr_ff;
   logic          clr_resp_ff;
   logic          rd_sel_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_byte_ff;
   logic [5:0]    page_ff;
   logic [8:0]    col_ff;
   logic [2:0]    off_ff;
   logic [7:0]    byte_ff;
   logic [7:0]    len_ff;
   logic [7:0]    col0_ff;
   logic [7:0]    width_ff;
   logic [7:0]    left_ff;

   logic [5:0] page_next;
   logic       page_ok;
   logic       next_page_ok;
   logic       col_ok;
   logic [5:0] m_page;
   logic [8:0] m_col;
   logic       m_ok;
   logic [7:0] head;
   logic [7:0] line_bits;
   logic [3:0] consume;
   logic [7:0] len_left;
   logic       rsp_free;
   func_type   func;

   function automatic logic [AW-1:0] addr_of(input logic [5:0] pg, input logic [8:0] cl);
      logic [FULL_AW-1:0] full;
      full = FULL_AW'(pg) * FULL_AW'(COLUMNS) + FULL_AW'(cl);
      return full[AW-1:0];
   endfunction

   assign func      = func_type'(req_if.func);
   assign page_next = page_ff + 6'd1;
   assign page_ok      = {1'b0, page_ff} < 7'(PAGES);
   assign next_page_ok = {1'b0, page_next} < 7'(PAGES);
   assign col_ok       = {1'b0, col_ff} < 10'(COLUMNS);

   // Merge target from tile origin, formed without wraparound
   assign m_page = {1'b0, req_if.start_row[7:3]} + {1'b0, req_if.tile_page};
   assign m_col  = {1'b0, req_if.start_col} + {1'b0, req_if.tile_col};
   assign m_ok   = ({1'b0, m_page} < 7'(PAGES)) && ({1'b0, m_col} < 10'(COLUMNS));

   // Line bits for the current page and rows left after it
   assign head      = (len_ff < 8'd8) ? ~(8'hFF >> len_ff[2:0]) : 8'hFF;
   assign line_bits = head >> off_ff;
   assign consume   = 4'd8 - {1'b0, off_ff};
   assign len_left  = (len_ff < {4'b0, consume}) ? 8'd0 : len_ff - {4'b0, consume};

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pixel_byte = rsp_byte_ff;

   // Issue store accesses from the current state
   always_comb begin
      cmd.op   = SOP_NONE;
      cmd.bits = byte_ff;
      cmd_addr = addr_of(page_ff, col_ff);
      case (state_ff)
         ST_CLEAR: begin
            cmd.op   = SOP_CLEAR;
            cmd_addr = clr_ff;
         end
         ST_MERGE_HI: begin
            cmd.op   = SOP_RMW;
            cmd.bits = byte_ff >> off_ff;
         end
         ST_MERGE_LO: begin
            cmd.op   = SOP_RMW;
            cmd.bits = byte_ff << (3'd0 - off_ff);
            cmd_addr = addr_of(page_next, col_ff);
         end
         ST_LINE_COL: begin
            if (left_ff != 8'd0 && col_ok) begin
               cmd.op = SOP_RMW;
            end
         end
         ST_READ: begin
            cmd.op = SOP_READ;
         end
         default: begin
            cmd.op = SOP_NONE;
         end
      endcase
   end

   // Sequence operations and hold the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         rd_sel_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop a taken response unless a new one is loaded this cycle
         if (rsp_valid_ff && rsp_if.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(DEPTH - 1)) begin
                  rd_sel_ff <= 1'b0;
                  state_ff  <= clr_resp_ff ? ST_DONE : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_if.valid) begin
                  rd_sel_ff <= 1'b0;
                  case (func)
                     FUNC_CLEAR: begin
                        clr_ff      <= '0;
                        clr_resp_ff <= 1'b1;
                        state_ff    <= ST_CLEAR;
                     end
                     FUNC_MERGE: begin
                        page_ff  <= m_page;
                        col_ff   <= m_col;
                        off_ff   <= req_if.start_row[2:0];
                        byte_ff  <= req_if.tile_byte;
                        state_ff <= m_ok ? ST_MERGE_HI : ST_DONE;
                     end
                     FUNC_LINE: begin
                        page_ff  <= {1'b0, req_if.start_row[7:3]};
                        off_ff   <= req_if.start_row[2:0];
                        len_ff   <= req_if.line_rows;
                        col0_ff  <= req_if.start_col;
                        width_ff <= req_if.line_cols;
                        if (req_if.line_rows != 8'd0 && req_if.line_cols != 8'd0) begin
                           state_ff <= ST_LINE_PAGE;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     FUNC_READ: begin
                        page_ff <= {2'b0, req_if.read_page};
                        col_ff  <= {1'b0, req_if.read_column};
                        if ({3'b0, req_if.read_page} < 7'(PAGES)
                            && {2'b0, req_if.read_column} < 10'(COLUMNS)) begin
                           state_ff <= ST_READ;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_MERGE_HI: begin
               // spill into the next page only when unaligned and on the panel
               if (off_ff != 3'd0 && next_page_ok) begin
                  state_ff <= ST_MERGE_LO;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_MERGE_LO: begin
               state_ff <= ST_DONE;
            end
            ST_LINE_PAGE: begin
               if (len_ff == 8'd0 || !page_ok) begin
                  state_ff <= ST_DONE;
               end else begin
                  byte_ff  <= line_bits;
                  len_ff   <= len_left;
                  off_ff   <= 3'd0;
                  col_ff   <= {1'b0, col0_ff};
                  left_ff  <= width_ff;
                  state_ff <= ST_LINE_COL;
               end
            end
            ST_LINE_COL: begin
               // advance along the row, drop to the next page at the clip edge or once the width is drawn
               if (left_ff == 8'd0 || !col_ok) begin
                  page_ff  <= page_next;
                  state_ff <= ST_LINE_PAGE;
               end else begin
                  col_ff  <= col_ff + 9'd1;
                  left_ff <= left_ff - 8'd1;
               end
            end
            ST_READ: begin
               rd_sel_ff <= 1'b1;
               state_ff  <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_byte_ff  <= rd_sel_ff ? rdata : 8'h00;
                  clr_resp_ff  <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
